// ===== hw/rtl/aescbc_pkg.sv =====
// AES-128 CBC core package: S-box tables, round constants, GF(2^8) helpers
// and register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package aescbc_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int ROUND_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_HIGH      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IV_LOW       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 3'd4;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   localparam byte_type FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam byte_type REV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   localparam byte_type ROUND_CONST [NUM_ROUNDS] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   localparam byte_type FWD_MIX [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
   localparam byte_type REV_MIX [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};

   // multiply by x modulo the AES polynomial
   function automatic byte_type xtime(input byte_type a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // multiply by a constant of at most four bits
   function automatic byte_type gf_mul(input byte_type a, input byte_type c);
      byte_type x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      gf_mul = (c[0] ? a : 8'h00) ^ (c[1] ? x2 : 8'h00) ^
               (c[2] ? x4 : 8'h00) ^ (c[3] ? x8 : 8'h00);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aescbc_if.sv =====
// Handshake channels of the AES-128 CBC core: request and response items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface aescbc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic        message_start;

   modport source (output valid, block_high, block_low, message_start, input ready);
   modport sink   (input valid, block_high, block_low, message_start, output ready);
endinterface

interface aescbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_high;
   logic [63:0] out_low;

   modport source (output valid, out_high, out_low, input ready);
   modport sink   (input valid, out_high, out_low, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/aescbc_keyexp.sv =====
// Round key expansion: one round key per cycle into an 11-entry key store.
// Depends on aescbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aescbc_keyexp
   import aescbc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                kick,
   input  wire block_type           key,
   input  wire logic [ROUND_W-1:0]  rd_idx,
   output      block_type           rd_key,
   output      logic                busy
);

   block_type            rk_mem [NUM_ROUNDS+1];
   block_type            prev_ff;
   logic [ROUND_W-1:0]   cnt_ff, cnt_in;
   logic                 active_ff, active_in;
   logic [31:0]          sub_word;
   block_type            next_key;

   // derive the next round key from the previous one
   always_comb begin
      logic [31:0] w0, w1, w2, w3, last;
      last = prev_ff[31:0];
      sub_word = {FWD_BOX[last[23:16]], FWD_BOX[last[15:8]],
                  FWD_BOX[last[7:0]], FWD_BOX[last[31:24]]};
      sub_word[31:24] = sub_word[31:24] ^ ROUND_CONST[cnt_ff - 4'd1];
      w0 = prev_ff[127:96] ^ sub_word;
      w1 = prev_ff[95:64] ^ w0;
      w2 = prev_ff[63:32] ^ w1;
      w3 = prev_ff[31:0] ^ w2;
      next_key = {w0, w1, w2, w3};
   end

   // advance the expansion counter
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      if (kick) begin
         active_in = 1'b1;
         cnt_in    = 4'd1;
      end else if (active_ff) begin
         if (cnt_ff == ROUND_W'(NUM_ROUNDS)) begin
            active_in = 1'b0;
         end
         cnt_in = cnt_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   // write the key store
   always_ff @(posedge clock) begin
      if (kick) begin
         rk_mem[0] <= key;
         prev_ff   <= key;
      end else if (active_ff) begin
         rk_mem[cnt_ff] <= next_key;
         prev_ff        <= next_key;
      end
   end

   assign rd_key = rk_mem[rd_idx];
   assign busy   = kick || active_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/aescbc_round.sv =====
// Shared AES round unit, both directions, one round per use.
// Depends on aescbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aescbc_round
   import aescbc_pkg::*;
(
   input  wire block_type  state,
   input  wire block_type  round_key,
   input  wire logic       decrypt,
   input  wire logic       last,
   output      block_type  result
);

   block_type shifted;
   block_type mixed;
   block_type mix_src;

   // substitute bytes and shift rows
   always_comb begin
      logic [1:0] src_col;
      logic [3:0] src;
      byte_type   b;
      shifted = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            src_col = decrypt ? 2'(c - r) : 2'(c + r);
            src     = 4'(r) + {src_col, 2'b00};
            b       = state[127 - 8*src -: 8];
            shifted[127 - 8*(r + 4*c) -: 8] = decrypt ? REV_BOX[b] : FWD_BOX[b];
         end
      end
   end

   assign mix_src = decrypt ? (shifted ^ round_key) : shifted;

   // mix columns
   always_comb begin
      byte_type v;
      byte_type m;
      mixed = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            v = '0;
            for (int k = 0; k < 4; k++) begin
               m = decrypt ? REV_MIX[2'(k - r)] : FWD_MIX[2'(k - r)];
               v = v ^ gf_mul(mix_src[127 - 8*(4*c + k) -: 8], m);
            end
            mixed[127 - 8*(4*c + r) -: 8] = v;
         end
      end
   end

   always_comb begin
      if (decrypt) begin
         result = last ? mix_src : mixed;
      end else begin
         result = (last ? shifted : mixed) ^ round_key;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/aes128_cbc_cipher_core.sv =====
// AES-128 CBC cipher core, encrypt or decrypt one 128-bit item at a time.
// Each accepted item is loaded with the first key add, makes ten passes
// through the shared round unit, and its result is loaded once the response
// register is free; no new item is taken before then. A key write re-expands
// the round keys, during which no item is taken. Reset (synchronous) clears
// key, IV, mode and chaining block and expands the all-zero key.
`timescale 1ns / 1ps
`default_nettype none
module aes128_cbc_cipher_core
   import aescbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   aescbc_req_if.sink                 req,
   aescbc_rsp_if.source               rsp,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;

   logic [63:0]        key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic               decrypt_cfg_ff;
   logic               kick_ff;
   logic [1:0]         st_ff, st_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               mode_ff, mode_in;
   block_type          state_ff, state_in;
   block_type          chain_ff, chain_in;
   block_type          cin_ff, cin_in;
   block_type          rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               load_rsp;

   logic               kexp_busy;
   logic [ROUND_W-1:0] rk_idx;
   block_type          rk;
   block_type          round_out;
   block_type          in_block;
   block_type          chain_sel;
   logic               accept;

   // hold configuration registers; a key write restarts expansion
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff    <= '0;
         key_low_ff     <= '0;
         iv_high_ff     <= '0;
         iv_low_ff      <= '0;
         decrypt_cfg_ff <= 1'b0;
         kick_ff        <= 1'b1;
      end else begin
         kick_ff <= csr_write_en &&
                    ((csr_index == CSR_KEY_HIGH) || (csr_index == CSR_KEY_LOW));
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_KEY_HIGH:     key_high_ff    <= csr_wdata;
               CSR_KEY_LOW:      key_low_ff     <= csr_wdata;
               CSR_IV_HIGH:      iv_high_ff     <= csr_wdata;
               CSR_IV_LOW:       iv_low_ff      <= csr_wdata;
               CSR_DECRYPT_MODE: decrypt_cfg_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   aescbc_keyexp u_keyexp (
      .clock  (clock),
      .reset  (reset),
      .kick   (kick_ff),
      .key    ({key_high_ff, key_low_ff}),
      .rd_idx (rk_idx),
      .rd_key (rk),
      .busy   (kexp_busy)
   );

   aescbc_round u_round (
      .state     (state_ff),
      .round_key (rk),
      .decrypt   (mode_ff),
      .last      (round_ff == ROUND_W'(NUM_ROUNDS)),
      .result    (round_out)
   );

   assign req.ready = (st_ff == ST_IDLE) && !kexp_busy;
   assign accept    = req.valid && req.ready;
   assign in_block  = {req.block_high, req.block_low};
   assign chain_sel = req.message_start ? {iv_high_ff, iv_low_ff} : chain_ff;

   // pick the round key: first key add at accept, then one per round
   always_comb begin
      if (st_ff == ST_ROUND) begin
         rk_idx = mode_ff ? (ROUND_W'(NUM_ROUNDS) - round_ff) : round_ff;
      end else begin
         rk_idx = decrypt_cfg_ff ? ROUND_W'(NUM_ROUNDS) : '0;
      end
   end

   // sequence one item through the round unit
   always_comb begin
      st_in        = st_ff;
      round_in     = round_ff;
      mode_in      = mode_ff;
      state_in     = state_ff;
      chain_in     = chain_ff;
      cin_in       = cin_ff;
      rsp_data_in  = rsp_data_ff;
      load_rsp     = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = decrypt_cfg_ff;
               chain_in = chain_sel;
               cin_in   = in_block;
               state_in = decrypt_cfg_ff ? (in_block ^ rk) : (in_block ^ chain_sel ^ rk);
               round_in = 4'd1;
               st_in    = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = round_out;
            if (round_ff == ROUND_W'(NUM_ROUNDS)) begin
               st_in = ST_DONE;
            end else begin
               round_in = round_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp    = 1'b1;
               rsp_data_in = mode_ff ? (state_ff ^ chain_ff) : state_ff;
               chain_in    = mode_ff ? cin_ff : state_ff;
               st_in       = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
      end else begin
         st_ff        <= st_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      state_ff    <= state_in;
      cin_ff      <= cin_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_high = rsp_data_ff[127:64];
   assign rsp.out_low  = rsp_data_ff[63:0];

endmodule
`default_nettype wire
